>>> design/capability_table_engine_top_defines.svh
// Assertion macros for the capability table engine.
// Used by the top level only; the clock i_clk and reset i_rst_n must be in scope.
`ifndef CAPABILITY_TABLE_ENGINE_TOP_DEFINES_SVH
`define CAPABILITY_TABLE_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CTE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CTE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/cte_pkg.sv
// Shared types and constants of the capability table engine.
// No dependencies; the design files that use it refer to it by scoped names, the testbench imports it.
package cte_pkg;

    localparam int NUM_CNODES_DEF = 4;
    localparam int SLOT_COUNT_DEF = 32;

    localparam int OP_W     = 3;
    localparam int CNODE_W  = 2;
    localparam int SLOT_W   = 8;
    localparam int KIND_W   = 4;
    localparam int RIGHTS_W = 8;
    localparam int BADGE_W  = 32;
    localparam int OBJECT_W = 32;
    localparam int PARENT_W = 8;
    localparam int STATUS_W = 3;

    localparam int Q_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP  = 3'd0,
        OP_INSTALL = 3'd1,
        OP_COPY    = 3'd2,
        OP_MINT    = 3'd3,
        OP_MOVE    = 3'd4,
        OP_DELETE  = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_OCCUPIED = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_TYPE     = 3'd4,
        ST_BADGED   = 3'd5
    } t_status;

    localparam logic [KIND_W-1:0]   KIND_NULL         = 4'd0;
    localparam logic [KIND_W-1:0]   KIND_ENDPOINT     = 4'd1;
    localparam logic [KIND_W-1:0]   KIND_NOTIFICATION = 4'd2;
    localparam logic [PARENT_W-1:0] NO_PARENT         = 8'hFF;
    localparam logic [RIGHTS_W-1:0] RIGHTS_ALL_RESET  = 8'hFF;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [RIGHTS_W-1:0] rights;
        logic [BADGE_W-1:0]  badge;
        logic [OBJECT_W-1:0] object;
        logic [PARENT_W-1:0] parent;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        kind:   KIND_NULL,
        rights: '0,
        badge:  '0,
        object: '0,
        parent: NO_PARENT
    };

    // A classified request as it travels through the queue.
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic                bad;
        logic [CNODE_W-1:0]  dst_cnode;
        logic [SLOT_W-1:0]   dst_slot;
        logic [CNODE_W-1:0]  src_cnode;
        logic [SLOT_W-1:0]   src_slot;
        logic [KIND_W-1:0]   kind;
        logic [RIGHTS_W-1:0] rights;
        logic [BADGE_W-1:0]  badge;
        logic [OBJECT_W-1:0] object;
        logic [PARENT_W-1:0] parent;
    } t_cmd;

endpackage

>>> design/cte_req_if.sv
// Request channel of the capability table engine: valid, ready and request fields.
// Depends on cte_pkg for the field widths.
interface cte_req_if;
    logic                           valid;
    logic                           ready;
    logic [cte_pkg::OP_W-1:0]       req_type;
    logic [cte_pkg::CNODE_W-1:0]    dst_cnode;
    logic [cte_pkg::SLOT_W-1:0]     dst_slot;
    logic [cte_pkg::CNODE_W-1:0]    src_cnode;
    logic [cte_pkg::SLOT_W-1:0]     src_slot;
    logic [cte_pkg::KIND_W-1:0]     cap_kind;
    logic [cte_pkg::RIGHTS_W-1:0]   rights_value;
    logic [cte_pkg::BADGE_W-1:0]    badge_value;
    logic [cte_pkg::OBJECT_W-1:0]   object_value;
    logic [cte_pkg::PARENT_W-1:0]   parent_value;

    modport source (
        output valid, req_type, dst_cnode, dst_slot, src_cnode, src_slot,
               cap_kind, rights_value, badge_value, object_value, parent_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, dst_cnode, dst_slot, src_cnode, src_slot,
               cap_kind, rights_value, badge_value, object_value, parent_value,
        output ready
    );
endinterface

>>> design/cte_rsp_if.sv
// Result channel of the capability table engine: valid, ready and result fields.
// Depends on cte_pkg for the field widths.
interface cte_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [cte_pkg::STATUS_W-1:0]   status;
    logic [cte_pkg::KIND_W-1:0]     out_kind;
    logic [cte_pkg::RIGHTS_W-1:0]   out_rights;
    logic [cte_pkg::BADGE_W-1:0]    out_badge;
    logic [cte_pkg::OBJECT_W-1:0]   out_object;
    logic [cte_pkg::PARENT_W-1:0]   out_parent;

    modport source (
        output valid, status, out_kind, out_rights, out_badge, out_object, out_parent,
        input  ready
    );
    modport sink (
        input  valid, status, out_kind, out_rights, out_badge, out_object, out_parent,
        output ready
    );
endinterface

>>> design/capability_table_engine_top.sv
// Top level of the capability table engine: front end, request queue, back end.
// Depends on cte_pkg, cte_req_if, cte_rsp_if, cte_front, cte_fifo, cte_back.
//
//  Channel   Direction  Handshake       Carries
//  i_req     in         valid / ready   one request (operation, slots, capability fields)
//  o_rsp     out        valid / ready   one result (status, looked-up slot fields)
//  i_cfg_*   in         write enable    rights_all_mask
//
// In the back end a request first reads both slots from the table RAM (registered
// read) as it is taken, then is checked and written; a successful move then clears
// its source in a separate write, since the RAM has a single write port.
// After reset a clearing pass writes every one of the NUM_CNODES * SLOT_COUNT slots
// (128 by default); no request is accepted during it.
// The two-entry queue keeps accepting while a result waits in the output register.

`include "capability_table_engine_top_defines.svh"

module capability_table_engine_top #(
    parameter int NUM_CNODES = cte_pkg::NUM_CNODES_DEF,
    parameter int SLOT_COUNT = cte_pkg::SLOT_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cte_pkg::RIGHTS_W-1:0]    i_cfg_wdata,
    cte_req_if.sink                         i_req,
    cte_rsp_if.source                       o_rsp
);

    logic            fifo_push;
    cte_pkg::t_cmd   fifo_cmd;
    logic            fifo_full;
    logic            fifo_pop;
    logic            head_valid;
    cte_pkg::t_cmd   head;
    logic            clearing;

    cte_front #(
        .NUM_CNODES (NUM_CNODES),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .i_req      (i_req),
        .i_full     (fifo_full),
        .i_clearing (clearing),
        .o_push     (fifo_push),
        .o_cmd      (fifo_cmd)
    );

    cte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_cmd   (fifo_cmd),
        .i_pop   (fifo_pop),
        .o_full  (fifo_full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    cte_back #(
        .NUM_CNODES (NUM_CNODES),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (fifo_pop),
        .o_clearing   (clearing),
        .o_rsp        (o_rsp)
    );

    `CTE_ASSERT_IMP(a_pop_needs_item, fifo_pop, head_valid, "pop from an empty request queue")
    `CTE_ASSERT_NXT(a_pop_spacing, fifo_pop, !fifo_pop, "back end took requests in consecutive cycles")
    `CTE_ASSERT_IMP(a_result_follows_pop, $rose(o_rsp.valid), $past(fifo_pop, 2), "result appeared without a request two cycles earlier")
    `CTE_ASSERT_IMP(a_no_pop_while_clearing, clearing, !fifo_pop && !i_req.ready, "request taken during the clearing pass")

endmodule

>>> design/cte_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module cte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                      o_rdata_a,
    output logic [WIDTH-1:0]                      o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> design/cte_front.sv
// Front end: accepts requests and classifies them (slot range checks, operation decode).
// Depends on cte_pkg and cte_req_if; feeds the request queue.
module cte_front #(
    parameter int NUM_CNODES = cte_pkg::NUM_CNODES_DEF,
    parameter int SLOT_COUNT = cte_pkg::SLOT_COUNT_DEF
) (
    cte_req_if.sink         i_req,
    input  logic            i_full,
    input  logic            i_clearing,
    output logic            o_push,
    output cte_pkg::t_cmd   o_cmd
);

    localparam logic [cte_pkg::CNODE_W:0] CNODE_LIM = (cte_pkg::CNODE_W + 1)'(NUM_CNODES);
    localparam logic [cte_pkg::SLOT_W:0]  SLOT_LIM  = (cte_pkg::SLOT_W + 1)'(SLOT_COUNT);

    logic dst_ok;
    logic src_ok;
    logic bad;

    assign dst_ok = ({1'b0, i_req.dst_cnode} < CNODE_LIM) && ({1'b0, i_req.dst_slot} < SLOT_LIM);
    assign src_ok = ({1'b0, i_req.src_cnode} < CNODE_LIM) && ({1'b0, i_req.src_slot} < SLOT_LIM);

    // Single-slot operations check only the target; pair operations check both.
    always_comb begin
        case (i_req.req_type) inside
            cte_pkg::OP_LOOKUP, cte_pkg::OP_INSTALL, cte_pkg::OP_DELETE: begin
                bad = !dst_ok;
            end
            cte_pkg::OP_COPY, cte_pkg::OP_MINT, cte_pkg::OP_MOVE: begin
                bad = !(src_ok && dst_ok);
            end
            default: begin
                bad = 1'b1;
            end
        endcase
    end

    assign i_req.ready = !i_full && !i_clearing;
    assign o_push      = i_req.valid && !i_full && !i_clearing;

    assign o_cmd = '{
        op:        i_req.req_type,
        bad:       bad,
        dst_cnode: i_req.dst_cnode,
        dst_slot:  i_req.dst_slot,
        src_cnode: i_req.src_cnode,
        src_slot:  i_req.src_slot,
        kind:      i_req.cap_kind,
        rights:    i_req.rights_value,
        badge:     i_req.badge_value,
        object:    i_req.object_value,
        parent:    i_req.parent_value
    };

endmodule

>>> design/cte_fifo.sv
// Short queue of classified requests between the front end and the back end.
// Depends on cte_pkg for the request type and the queue depth.
module cte_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cte_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output cte_pkg::t_cmd   o_head
);

    localparam int PW = (cte_pkg::Q_DEPTH > 1) ? $clog2(cte_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(cte_pkg::Q_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(cte_pkg::Q_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(cte_pkg::Q_DEPTH);

    cte_pkg::t_cmd   r_data [cte_pkg::Q_DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CW-1:0]   r_count;
    logic            push_ok;
    logic            pop_ok;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_data[r_rptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_data[r_wptr] <= i_cmd;
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> design/cte_back.sv
// Back end: holds the slot table in RAM, executes one request at a time, keeps the
// rights mask register and the result register. Depends on cte_pkg, cte_rsp_if, cte_ram.
module cte_back #(
    parameter int NUM_CNODES = cte_pkg::NUM_CNODES_DEF,
    parameter int SLOT_COUNT = cte_pkg::SLOT_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cte_pkg::RIGHTS_W-1:0]    i_cfg_wdata,
    input  logic                            i_head_valid,
    input  cte_pkg::t_cmd                   i_head,
    output logic                            o_pop,
    output logic                            o_clearing,
    cte_rsp_if.source                       o_rsp
);

    localparam int TOTAL = NUM_CNODES * SLOT_COUNT;
    localparam int IDX_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int EW    = $bits(cte_pkg::t_entry);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOTAL - 1);
    localparam logic [IDX_W-1:0] SLOTS    = IDX_W'(SLOT_COUNT);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WIPE
    } t_state;

    t_state                         r_state;
    logic [IDX_W-1:0]               r_clr_idx;
    logic [IDX_W-1:0]               r_src_idx;
    logic [IDX_W-1:0]               r_dst_idx;
    cte_pkg::t_cmd                  r_cmd;
    logic [cte_pkg::RIGHTS_W-1:0]   r_mask;
    logic                           r_out_valid;
    cte_pkg::t_status               r_out_status;
    cte_pkg::t_entry                r_out_entry;

    logic [IDX_W-1:0]   head_src_idx;
    logic [IDX_W-1:0]   head_dst_idx;
    logic [EW-1:0]      rd_a;
    logic [EW-1:0]      rd_b;
    cte_pkg::t_entry    src_e;
    cte_pkg::t_entry    dst_e;
    cte_pkg::t_entry    derived;
    logic               is_mint;

    cte_pkg::t_status   ex_status;
    logic               ex_we;
    cte_pkg::t_entry    ex_wdata;
    logic               ex_wipe;
    logic               ex_lookup;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    cte_pkg::t_entry    ram_wdata;

    assign head_src_idx = IDX_W'(i_head.src_cnode) * SLOTS + IDX_W'(i_head.src_slot);
    assign head_dst_idx = IDX_W'(i_head.dst_cnode) * SLOTS + IDX_W'(i_head.dst_slot);

    // The next request starts only once the result register is free or draining,
    // so the result of this request always finds room.
    assign o_pop      = (r_state == S_IDLE) && i_head_valid && (!r_out_valid || o_rsp.ready);
    assign o_clearing = (r_state == S_CLEAR);

    cte_ram #(
        .WIDTH (EW),
        .DEPTH (TOTAL)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (head_src_idx),
        .i_raddr_b (head_dst_idx),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign src_e   = cte_pkg::t_entry'(rd_a);
    assign dst_e   = cte_pkg::t_entry'(rd_b);
    assign is_mint = (r_cmd.op == cte_pkg::OP_MINT);

    // Copy and mint point the new parent at the source slot number within its cnode.
    assign derived = '{
        kind:   src_e.kind,
        rights: src_e.rights & r_cmd.rights & r_mask,
        badge:  is_mint ? r_cmd.badge : src_e.badge,
        object: src_e.object,
        parent: r_cmd.src_slot
    };

    always_comb begin
        ex_status = cte_pkg::ST_OK;
        ex_we     = 1'b0;
        ex_wdata  = src_e;
        ex_wipe   = 1'b0;
        ex_lookup = 1'b0;
        case (r_cmd.op)
            cte_pkg::OP_LOOKUP: begin
                if (r_cmd.bad) begin
                    ex_status = cte_pkg::ST_INVALID;
                end else begin
                    ex_lookup = 1'b1;
                end
            end
            cte_pkg::OP_INSTALL: begin
                if (r_cmd.bad) begin
                    ex_status = cte_pkg::ST_INVALID;
                end else if (dst_e.kind != cte_pkg::KIND_NULL) begin
                    ex_status = cte_pkg::ST_OCCUPIED;
                end else begin
                    ex_we    = 1'b1;
                    ex_wdata = '{
                        kind:   r_cmd.kind,
                        rights: r_cmd.rights,
                        badge:  r_cmd.badge,
                        object: r_cmd.object,
                        parent: r_cmd.parent
                    };
                end
            end
            cte_pkg::OP_COPY, cte_pkg::OP_MINT: begin
                if (r_cmd.bad) begin
                    ex_status = cte_pkg::ST_INVALID;
                end else if (src_e.kind == cte_pkg::KIND_NULL) begin
                    ex_status = cte_pkg::ST_EMPTY;
                end else if (dst_e.kind != cte_pkg::KIND_NULL) begin
                    ex_status = cte_pkg::ST_OCCUPIED;
                end else if (is_mint && !(src_e.kind inside
                        {cte_pkg::KIND_ENDPOINT, cte_pkg::KIND_NOTIFICATION})) begin
                    ex_status = cte_pkg::ST_TYPE;
                end else if (is_mint && (src_e.badge != '0)) begin
                    ex_status = cte_pkg::ST_BADGED;
                end else begin
                    ex_we    = 1'b1;
                    ex_wdata = derived;
                end
            end
            cte_pkg::OP_MOVE: begin
                if (r_cmd.bad) begin
                    ex_status = cte_pkg::ST_INVALID;
                end else if (src_e.kind == cte_pkg::KIND_NULL) begin
                    ex_status = cte_pkg::ST_EMPTY;
                end else if (dst_e.kind != cte_pkg::KIND_NULL) begin
                    ex_status = cte_pkg::ST_OCCUPIED;
                end else begin
                    ex_we    = 1'b1;
                    ex_wdata = src_e;
                    ex_wipe  = 1'b1;
                end
            end
            cte_pkg::OP_DELETE: begin
                if (r_cmd.bad) begin
                    ex_status = cte_pkg::ST_INVALID;
                end else if (dst_e.kind == cte_pkg::KIND_NULL) begin
                    ex_status = cte_pkg::ST_EMPTY;
                end else begin
                    ex_we    = 1'b1;
                    ex_wdata = cte_pkg::ENTRY_RESET;
                end
            end
            default: begin
                ex_status = cte_pkg::ST_INVALID;
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_dst_idx;
        ram_wdata = ex_wdata;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = cte_pkg::ENTRY_RESET;
            end
            S_EXEC: begin
                ram_we = ex_we;
            end
            S_WIPE: begin
                ram_we    = 1'b1;
                ram_waddr = r_src_idx;
                ram_wdata = cte_pkg::ENTRY_RESET;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_mask      <= cte_pkg::RIGHTS_ALL_RESET;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd     <= i_head;
                        r_src_idx <= head_src_idx;
                        r_dst_idx <= head_dst_idx;
                        r_state   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_out_valid  <= 1'b1;
                    r_out_status <= ex_status;
                    r_out_entry  <= ex_lookup ? dst_e : '0;
                    r_state      <= ex_wipe ? S_WIPE : S_IDLE;
                end
                S_WIPE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.out_kind   = r_out_entry.kind;
    assign o_rsp.out_rights = r_out_entry.rights;
    assign o_rsp.out_badge  = r_out_entry.badge;
    assign o_rsp.out_object = r_out_entry.object;
    assign o_rsp.out_parent = r_out_entry.parent;

endmodule

>>> verif/capability_table_engine_top_test.sv
// Self-checking testbench for capability_table_engine_top: a directed table, then random requests.
// Depends on cte_pkg, cte_req_if and cte_rsp_if from the design, and on the top level itself.
module capability_table_engine_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cte_pkg::*;

    localparam int NUM_CNODES = cte_pkg::NUM_CNODES_DEF;
    localparam int SLOT_COUNT = cte_pkg::SLOT_COUNT_DEF;
    localparam int TABLE_SIZE = NUM_CNODES * SLOT_COUNT;

    localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [CNODE_W-1:0] dst_cnode;
        logic [SLOT_W-1:0]  dst_slot;
        logic [CNODE_W-1:0] src_cnode;
        logic [SLOT_W-1:0]  src_slot;
        t_entry             cap;    // rights doubles as the derive mask, badge as the mint badge
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_entry              slot;
    } t_result;

    typedef struct {
        t_request req;
        bit       typed;
        t_result  want;
    } t_row;

    localparam t_entry NO_CAP   = '0;
    localparam t_entry FULL_CAP = '1;
    localparam t_entry EP_CAP   = '{kind: KIND_ENDPOINT, rights: 8'hFF, badge: '0,
                                    object: 32'hFFFF_FFFF, parent: NO_PARENT};

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [RIGHTS_W-1:0] i_cfg_wdata;

    cte_req_if req_bus();
    cte_rsp_if rsp_bus();

    capability_table_engine_top #(
        .NUM_CNODES(NUM_CNODES),
        .SLOT_COUNT(SLOT_COUNT)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus)
    );

    // Shadow copy of the capability table and the rights register.
    t_entry              cap_table [TABLE_SIZE];
    logic [RIGHTS_W-1:0] all_rights;
    t_result             outstanding_results [$];

    int unsigned sender_idle_pct   = 27;
    int unsigned receiver_idle_pct = 76;
    int unsigned failures          = 0;
    int unsigned results_seen      = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= 10) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic bit slot_index(input logic [CNODE_W-1:0] cn, input logic [SLOT_W-1:0] sl,
                                      output int unsigned idx);
        idx = cn * SLOT_COUNT + sl;
        return (cn < NUM_CNODES) && (sl < SLOT_COUNT);
    endfunction

    // Applies one request to the shadow table and returns the result it should produce.
    function automatic t_result apply_request(input t_request r);
        t_result     res;
        t_entry      derived;
        int unsigned d;
        int unsigned s;
        bit          d_ok;
        bit          s_ok;
        res  = '0;
        d_ok = slot_index(r.dst_cnode, r.dst_slot, d);
        s_ok = slot_index(r.src_cnode, r.src_slot, s);
        case (r.op)
            OP_LOOKUP: begin
                if (!d_ok) begin
                    res.status = ST_INVALID;
                end else begin
                    res.slot = cap_table[d];
                end
            end
            OP_INSTALL: begin
                if (!d_ok) begin
                    res.status = ST_INVALID;
                end else if (cap_table[d].kind != KIND_NULL) begin
                    res.status = ST_OCCUPIED;
                end else begin
                    cap_table[d] = r.cap;
                end
            end
            OP_COPY, OP_MINT, OP_MOVE: begin
                if (!s_ok || !d_ok) begin
                    res.status = ST_INVALID;
                end else if (cap_table[s].kind == KIND_NULL) begin
                    res.status = ST_EMPTY;
                end else if (cap_table[d].kind != KIND_NULL) begin
                    res.status = ST_OCCUPIED;
                end else if (r.op == OP_MINT && cap_table[s].kind != KIND_ENDPOINT &&
                             cap_table[s].kind != KIND_NOTIFICATION) begin
                    res.status = ST_TYPE;
                end else if (r.op == OP_MINT && cap_table[s].badge != '0) begin
                    res.status = ST_BADGED;
                end else if (r.op == OP_MOVE) begin
                    cap_table[d] = cap_table[s];
                    cap_table[s] = ENTRY_RESET;
                end else begin
                    // The derived parent is the source slot number within its cnode.
                    derived        = cap_table[s];
                    derived.rights = derived.rights & r.cap.rights & all_rights;
                    derived.parent = r.src_slot;
                    if (r.op == OP_MINT) begin
                        derived.badge = r.cap.badge;
                    end
                    cap_table[d] = derived;
                end
            end
            OP_DELETE: begin
                if (!d_ok) begin
                    res.status = ST_INVALID;
                end else if (cap_table[d].kind == KIND_NULL) begin
                    res.status = ST_EMPTY;
                end else begin
                    cap_table[d] = ENTRY_RESET;
                end
            end
            default: begin
                res.status = ST_INVALID;
            end
        endcase
        return res;
    endfunction

    function automatic t_entry make_cap(input logic [KIND_W-1:0] k, input logic [RIGHTS_W-1:0] rt,
                                        input logic [BADGE_W-1:0] b, input logic [OBJECT_W-1:0] o,
                                        input logic [PARENT_W-1:0] p);
        t_entry e;
        e.kind   = k;
        e.rights = rt;
        e.badge  = b;
        e.object = o;
        e.parent = p;
        return e;
    endfunction

    function automatic t_row mk_row(input logic [OP_W-1:0] op,
                                    input logic [CNODE_W-1:0] dc, input logic [SLOT_W-1:0] ds,
                                    input logic [CNODE_W-1:0] sc, input logic [SLOT_W-1:0] ss,
                                    input t_entry cap, input bit typed,
                                    input logic [STATUS_W-1:0] st, input t_entry shown);
        t_row row;
        row.req.op        = op;
        row.req.dst_cnode = dc;
        row.req.dst_slot  = ds;
        row.req.src_cnode = sc;
        row.req.src_slot  = ss;
        row.req.cap       = cap;
        row.typed         = typed;
        row.want.status   = st;
        row.want.slot     = shown;
        return row;
    endfunction

    // Picks a slot, usually valid, and tries to hit an occupied or an empty one as asked.
    function automatic void pick_slot(input int unsigned full_pct,
                                      output logic [CNODE_W-1:0] cn, output logic [SLOT_W-1:0] sl);
        bit want_full;
        want_full = ($urandom_range(99) < full_pct);
        cn = CNODE_W'($urandom_range(NUM_CNODES - 1));
        if ($urandom_range(99) < 10) begin
            sl = SLOT_W'($urandom_range(255, SLOT_COUNT));
        end else begin
            for (int t = 0; t < 16; t++) begin
                cn = CNODE_W'($urandom_range(NUM_CNODES - 1));
                sl = SLOT_W'($urandom_range(SLOT_COUNT - 1));
                if ((cap_table[cn * SLOT_COUNT + sl].kind != KIND_NULL) == want_full) begin
                    break;
                end
            end
        end
    endfunction

    function automatic t_request random_request();
        t_request    r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 16) begin
            r.op = OP_LOOKUP;
        end else if (pick < 36) begin
            r.op = OP_INSTALL;
        end else if (pick < 52) begin
            r.op = OP_COPY;
        end else if (pick < 68) begin
            r.op = OP_MINT;
        end else if (pick < 80) begin
            r.op = OP_MOVE;
        end else if (pick < 94) begin
            r.op = OP_DELETE;
        end else begin
            r.op = (pick < 97) ? OP_UNDEF_LO : OP_UNDEF_HI;
        end
        pick = $urandom_range(99);
        if (pick < 40) begin
            r.cap.kind = KIND_ENDPOINT;
        end else if (pick < 65) begin
            r.cap.kind = KIND_NOTIFICATION;
        end else if (pick < 75) begin
            r.cap.kind = KIND_NULL;
        end else begin
            r.cap.kind = KIND_W'($urandom_range(15));
        end
        r.cap.rights = ($urandom_range(3) == 0) ? 8'hFF : RIGHTS_W'($urandom_range(255));
        // Zero badges are common so that mint finds unbadged sources.
        r.cap.badge  = ($urandom_range(1) == 0) ? '0 : BADGE_W'($urandom);
        r.cap.object = OBJECT_W'($urandom);
        r.cap.parent = ($urandom_range(4) == 0) ? NO_PARENT : PARENT_W'($urandom_range(255));
        case (r.op)
            OP_LOOKUP: pick_slot(50, r.dst_cnode, r.dst_slot);
            OP_DELETE: pick_slot(75, r.dst_cnode, r.dst_slot);
            default:   pick_slot(20, r.dst_cnode, r.dst_slot);
        endcase
        pick_slot(85, r.src_cnode, r.src_slot);
        if ((r.op == OP_COPY || r.op == OP_MINT || r.op == OP_MOVE) &&
            $urandom_range(19) == 0) begin
            r.dst_cnode = r.src_cnode;
            r.dst_slot  = r.src_slot;
        end
        return r;
    endfunction

    task automatic drive_fields(input t_request r);
        req_bus.req_type     <= r.op;
        req_bus.dst_cnode    <= r.dst_cnode;
        req_bus.dst_slot     <= r.dst_slot;
        req_bus.src_cnode    <= r.src_cnode;
        req_bus.src_slot     <= r.src_slot;
        req_bus.cap_kind     <= r.cap.kind;
        req_bus.rights_value <= r.cap.rights;
        req_bus.badge_value  <= r.cap.badge;
        req_bus.object_value <= r.cap.object;
        req_bus.parent_value <= r.cap.parent;
    endtask

    // Presents one request, waits for its acceptance and records the result it owes.
    task automatic send_request(input t_row row);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        drive_fields(row.req);
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        if (row.typed) begin
            void'(apply_request(row.req));
            outstanding_results.push_back(row.want);
        end else begin
            outstanding_results.push_back(apply_request(row.req));
        end
    endtask

    task automatic drain_results();
        req_bus.valid <= 1'b0;
        while (outstanding_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_all_mask(input logic [RIGHTS_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        all_rights = value;
    endtask

    task automatic run_random(input int unsigned send_pct, input int unsigned recv_pct,
                              input int unsigned count);
        t_row row;
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        row.typed = 1'b0;
        row.want  = '0;
        repeat (count) begin
            row.req = random_request();
            send_request(row);
        end
    endtask

    function automatic string show_result(input t_result r);
        return $sformatf("status=%0d kind=%0h rights=%02h badge=%08h object=%08h parent=%02h",
                         r.status, r.slot.kind, r.slot.rights, r.slot.badge, r.slot.object,
                         r.slot.parent);
    endfunction

    initial begin : result_monitor
        t_result got;
        t_result want;
        string   diff;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
                got.status      = rsp_bus.status;
                got.slot.kind   = rsp_bus.out_kind;
                got.slot.rights = rsp_bus.out_rights;
                got.slot.badge  = rsp_bus.out_badge;
                got.slot.object = rsp_bus.out_object;
                got.slot.parent = rsp_bus.out_parent;
                results_seen++;
                if (outstanding_results.size() == 0) begin
                    report_failure($sformatf("result %0d arrived with none owed: %s",
                                             results_seen, show_result(got)));
                end else begin
                    want = outstanding_results.pop_front();
                    diff = "";
                    if (got.status !== want.status) diff = {diff, " status"};
                    if (got.slot.kind !== want.slot.kind) diff = {diff, " kind"};
                    if (got.slot.rights !== want.slot.rights) diff = {diff, " rights"};
                    if (got.slot.badge !== want.slot.badge) diff = {diff, " badge"};
                    if (got.slot.object !== want.slot.object) diff = {diff, " object"};
                    if (got.slot.parent !== want.slot.parent) diff = {diff, " parent"};
                    if (diff.len() != 0) begin
                        report_failure($sformatf("result %0d differs in%s: expected %s, got %s",
                                                 results_seen, diff, show_result(want),
                                                 show_result(got)));
                    end
                end
            end
            rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    initial begin : watchdog
        // Far beyond the slowest legal run, clearing pass included.
        #400_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        t_row rows [$];
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        req_bus.valid <= 1'b0;
        drive_fields('0);
        all_rights = RIGHTS_ALL_RESET;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            cap_table[i] = ENTRY_RESET;
        end

        // Reset contents, invalid slots, unknown operations and a delete of an empty slot.
        rows.push_back(mk_row(OP_LOOKUP, 2'd0, 8'd0, 2'd0, 8'd0, NO_CAP, 1'b1, ST_OK,
                              ENTRY_RESET));
        rows.push_back(mk_row(OP_LOOKUP, 2'd0, 8'd32, 2'd0, 8'd0, NO_CAP, 1'b1, ST_INVALID,
                              NO_CAP));
        rows.push_back(mk_row(OP_UNDEF_LO, 2'd0, 8'd0, 2'd0, 8'd0, NO_CAP, 1'b1, ST_INVALID,
                              NO_CAP));
        rows.push_back(mk_row(OP_UNDEF_HI, 2'd3, 8'd255, 2'd3, 8'd255, FULL_CAP, 1'b1,
                              ST_INVALID, NO_CAP));
        rows.push_back(mk_row(OP_DELETE, 2'd1, 8'd5, 2'd0, 8'd0, NO_CAP, 1'b1, ST_EMPTY,
                              NO_CAP));
        // Install, then occupied and invalid targets, then read it back.
        rows.push_back(mk_row(OP_INSTALL, 2'd0, 8'd0, 2'd0, 8'd0, EP_CAP, 1'b1, ST_OK,
                              NO_CAP));
        rows.push_back(mk_row(OP_INSTALL, 2'd0, 8'd0, 2'd0, 8'd0, FULL_CAP, 1'b1, ST_OCCUPIED,
                              NO_CAP));
        rows.push_back(mk_row(OP_INSTALL, 2'd3, 8'd255, 2'd0, 8'd0, EP_CAP, 1'b1, ST_INVALID,
                              NO_CAP));
        rows.push_back(mk_row(OP_LOOKUP, 2'd0, 8'd0, 2'd0, 8'd0, NO_CAP, 1'b1, ST_OK, EP_CAP));
        // Derivations: copy, a mint, and the mint error cases.
        rows.push_back(mk_row(OP_COPY, 2'd1, 8'd3, 2'd0, 8'd0,
                              make_cap(KIND_NULL, 8'h0F, '0, '0, '0), 1'b0, ST_OK, NO_CAP));
        rows.push_back(mk_row(OP_MINT, 2'd2, 8'd7, 2'd1, 8'd3,
                              make_cap(KIND_NULL, 8'hAA, 32'hFFFF_FFFF, '0, '0), 1'b0, ST_OK,
                              NO_CAP));
        rows.push_back(mk_row(OP_MINT, 2'd2, 8'd8, 2'd2, 8'd7,
                              make_cap(KIND_NULL, 8'hFF, 32'h1, '0, '0), 1'b1, ST_BADGED,
                              NO_CAP));
        rows.push_back(mk_row(OP_INSTALL, 2'd3, 8'd31, 2'd0, 8'd0,
                              make_cap(4'hF, 8'h55, '0, '0, '0), 1'b0, ST_OK, NO_CAP));
        rows.push_back(mk_row(OP_MINT, 2'd3, 8'd30, 2'd3, 8'd31, NO_CAP, 1'b1, ST_TYPE,
                              NO_CAP));
        // Status order: validity first, then empty source, then occupied target.
        rows.push_back(mk_row(OP_COPY, 2'd1, 8'd9, 2'd0, 8'd40, NO_CAP, 1'b1, ST_INVALID,
                              NO_CAP));
        rows.push_back(mk_row(OP_COPY, 2'd0, 8'd200, 2'd1, 8'd1, NO_CAP, 1'b1, ST_INVALID,
                              NO_CAP));
        rows.push_back(mk_row(OP_COPY, 2'd1, 8'd2, 2'd1, 8'd1, NO_CAP, 1'b1, ST_EMPTY,
                              NO_CAP));
        rows.push_back(mk_row(OP_MOVE, 2'd0, 8'd0, 2'd0, 8'd0, NO_CAP, 1'b1, ST_OCCUPIED,
                              NO_CAP));
        rows.push_back(mk_row(OP_COPY, 2'd1, 8'd3, 2'd0, 8'd0, NO_CAP, 1'b1, ST_OCCUPIED,
                              NO_CAP));
        // A move keeps the parent and clears its source.
        rows.push_back(mk_row(OP_MOVE, 2'd3, 8'd0, 2'd0, 8'd0, NO_CAP, 1'b0, ST_OK, NO_CAP));
        rows.push_back(mk_row(OP_LOOKUP, 2'd0, 8'd0, 2'd0, 8'd0, NO_CAP, 1'b0, ST_OK, NO_CAP));
        rows.push_back(mk_row(OP_LOOKUP, 2'd3, 8'd0, 2'd0, 8'd0, NO_CAP, 1'b0, ST_OK, NO_CAP));
        // A null capability is stored but leaves the slot free for the next install.
        rows.push_back(mk_row(OP_INSTALL, 2'd2, 8'd20, 2'd0, 8'd0,
                              make_cap(KIND_NULL, 8'h33, 32'h1234_5678, 32'hABCD_EF01, 8'd7),
                              1'b0, ST_OK, NO_CAP));
        rows.push_back(mk_row(OP_INSTALL, 2'd2, 8'd20, 2'd0, 8'd0,
                              make_cap(KIND_NOTIFICATION, '0, '0, '0, '0), 1'b0, ST_OK,
                              NO_CAP));
        rows.push_back(mk_row(OP_DELETE, 2'd3, 8'd0, 2'd0, 8'd0, NO_CAP, 1'b0, ST_OK, NO_CAP));
        rows.push_back(mk_row(OP_DELETE, 2'd0, 8'd0, 2'd0, 8'd0, NO_CAP, 1'b1, ST_EMPTY,
                              NO_CAP));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            send_request(rows[i]);
        end

        run_random(27, 76, 220);
        write_all_mask(8'h00);
        run_random(27, 76, 200);
        write_all_mask(8'hA5);
        run_random(76, 27, 220);
        write_all_mask(8'hFF);
        run_random(76, 27, 220);
        write_all_mask(RIGHTS_W'($urandom_range(255)));
        run_random(0, 0, 220);
        write_all_mask(8'h5A);
        run_random(0, 0, 220);

        drain_results();
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> capability_table_engine_top.f
+incdir+design
design/cte_pkg.sv
design/cte_req_if.sv
design/cte_rsp_if.sv
design/cte_ram.sv
design/cte_front.sv
design/cte_fifo.sv
design/cte_back.sv
design/capability_table_engine_top.sv
verif/capability_table_engine_top_test.sv
